>>> hw/rtl/ctfl_pkg.sv
// Shared types and codes for the context tag free list.
// No dependencies; used by ctfl_mem and context_tag_free_list.
package ctfl_pkg;

  localparam int TAG_W = 8;
  localparam int CTX_W = 64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic ctx_we;
  } mem_ctl_t;

endpackage

>>> hw/rtl/ctfl_mem.sv
// Link and context memories of the tag free list, with the post-reset link sweep.
// Depends on ctfl_pkg (mem_ctl_t, CTX_W).
module ctfl_mem #(
  parameter int TAG_COUNT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ctfl_pkg::mem_ctl_t                ctl,
  input  logic [$clog2(TAG_COUNT)-1:0]      link_raddr,
  input  logic [$clog2(TAG_COUNT)-1:0]      ctx_raddr,
  input  logic [$clog2(TAG_COUNT)-1:0]      link_waddr,
  input  logic [$clog2(TAG_COUNT+1)-1:0]    link_wdata,
  input  logic [$clog2(TAG_COUNT)-1:0]      ctx_waddr,
  input  logic [ctfl_pkg::CTX_W-1:0]        ctx_wdata,
  output logic [$clog2(TAG_COUNT+1)-1:0]    link_rdata,
  output logic [ctfl_pkg::CTX_W-1:0]        ctx_rdata,
  output logic                              ready
);

  localparam int IW = $clog2(TAG_COUNT);
  localparam int HW = $clog2(TAG_COUNT + 1);

  logic [HW-1:0]                 link_mem [TAG_COUNT];
  logic [ctfl_pkg::CTX_W-1:0]    ctx_mem  [TAG_COUNT];

  logic          clr_active;
  logic [IW-1:0] clr_cnt;
  logic          lwe;
  logic [IW-1:0] lwa;
  logic [HW-1:0] lwd;

  // sweep rebuilds the chain i -> i+1, last entry -> end marker
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_cnt    <= '0;
      ready      <= 1'b0;
    end else if (clr_active) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == IW'(TAG_COUNT - 1)) begin
        clr_active <= 1'b0;
        ready      <= 1'b1;
      end
    end
  end

  always_comb begin
    lwe = ctl.link_we;
    lwa = link_waddr;
    lwd = link_wdata;
    if (clr_active) begin
      lwe = 1'b1;
      lwa = clr_cnt;
      lwd = HW'(clr_cnt) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      link_mem[lwa] <= lwd;
    end
    if (ctl.rd_en) begin
      link_rdata <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ctx_we) begin
      ctx_mem[ctx_waddr] <= ctx_wdata;
    end
    if (ctl.rd_en) begin
      ctx_rdata <= ctx_mem[ctx_raddr];
    end
  end

endmodule

>>> hw/rtl/context_tag_free_list.sv
// Top level of the context tag free list: command sequencer around ctfl_mem.
// Depends on ctfl_pkg and ctfl_mem.

// Completion-tag allocator on a linked free list of TAG_COUNT slots. A command is
// taken when start is high and busy is low; allocate (command 0) pops the head slot,
// stores context_value there and returns the slot in tag_index, or reports status 1
// when no slot is free; free (command 1) returns the stored context and pushes
// release_tag back as the new head, or returns zero if release_tag >= TAG_COUNT.
// A command reads the link and context memories in the cycle it is accepted, writes
// back and updates the head in the execute state; the result shows with done for one
// cycle, in the cycle after the execute state, and cannot be held off. After reset,
// busy stays high while the link memory is swept into its initial chain.
module context_tag_free_list #(
  parameter int TAG_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [ctfl_pkg::CTX_W-1:0]   context_value,
  input  logic [ctfl_pkg::TAG_W-1:0]   release_tag,
  output logic                         done,
  output logic [ctfl_pkg::TAG_W-1:0]   tag_index,
  output logic [ctfl_pkg::CTX_W-1:0]   returned_context,
  output logic                         status
);

  localparam int IW = $clog2(TAG_COUNT);
  localparam int HW = $clog2(TAG_COUNT + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                        state;
  logic [HW-1:0]                 head;
  logic                          cmd_q;
  logic [ctfl_pkg::CTX_W-1:0]    ctx_q;
  logic [ctfl_pkg::TAG_W-1:0]    idx_q;

  ctfl_pkg::mem_ctl_t            ctl;
  logic [HW-1:0]                 link_rdata;
  logic [ctfl_pkg::CTX_W-1:0]    ctx_rdata;
  logic                          mem_ready;
  logic                          accept;
  logic                          empty;
  logic                          in_range;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign empty    = (head >= HW'(TAG_COUNT));
  assign in_range = (32'(idx_q) < 32'(TAG_COUNT));

  always_comb begin
    ctl         = '0;
    ctl.rd_en   = accept;
    ctl.ctx_we  = (state == ST_EXEC) && (cmd_q == ctfl_pkg::CMD_ALLOC) && !empty;
    ctl.link_we = (state == ST_EXEC) && (cmd_q == ctfl_pkg::CMD_FREE) && in_range;
  end

  ctfl_mem #(
    .TAG_COUNT(TAG_COUNT)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .link_raddr (head[IW-1:0]),
    .ctx_raddr  (IW'(release_tag)),
    .link_waddr (IW'(idx_q)),
    .link_wdata (head),
    .ctx_waddr  (head[IW-1:0]),
    .ctx_wdata  (ctx_q),
    .link_rdata (link_rdata),
    .ctx_rdata  (ctx_rdata),
    .ready      (mem_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      head  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (mem_ready) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q <= command;
            ctx_q <= context_value;
            idx_q <= release_tag;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (cmd_q == ctfl_pkg::CMD_ALLOC) begin
            returned_context <= '0;
            if (empty) begin
              tag_index <= '0;
              status    <= ctfl_pkg::STATUS_EMPTY;
            end else begin
              tag_index <= ctfl_pkg::TAG_W'(head);
              status    <= ctfl_pkg::STATUS_DONE;
              head      <= link_rdata;
            end
          end else begin
            tag_index <= idx_q;
            status    <= ctfl_pkg::STATUS_DONE;
            if (in_range) begin
              returned_context <= ctx_rdata;
              head             <= HW'(idx_q);
            end else begin
              returned_context <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result beat without execute cycle");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted command gave no result beat");

  a_head_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (head <= HW'(TAG_COUNT)))
    else $error("free list head beyond end marker");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ctfl_pkg::STATUS_EMPTY) |->
      (tag_index == '0 && returned_context == '0 && $past(empty)))
    else $error("empty status with nonzero payload");
`endif

endmodule

>>> dv/tb_context_tag_free_list.sv
// Testbench for context_tag_free_list: a directed table, then random allocate/free traffic.
// Every done beat is checked against the table's expected reply or an in-bench free list predictor.
// Depends on ctfl_pkg and the context_tag_free_list RTL.
module tb_context_tag_free_list;

  localparam int TAGS = 256;
  localparam int N_RANDOM = 1800;
  localparam int N_DIR = 16;

  typedef struct packed {
    logic [ctfl_pkg::TAG_W-1:0] tag;
    logic [ctfl_pkg::CTX_W-1:0] ctx;
    logic                       status;
  } tag_reply_t;

  typedef struct packed {
    logic                       cmd;
    logic [ctfl_pkg::CTX_W-1:0] ctx;
    logic [ctfl_pkg::TAG_W-1:0] idx;
    logic                       typed;
    tag_reply_t                 reply;
  } dir_row_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       command;
  logic [ctfl_pkg::CTX_W-1:0] context_value;
  logic [ctfl_pkg::TAG_W-1:0] release_tag;
  logic                       done;
  logic [ctfl_pkg::TAG_W-1:0] tag_index;
  logic [ctfl_pkg::CTX_W-1:0] returned_context;
  logic                       status;

  // predictor state
  logic [8:0]                 next_free [TAGS];
  logic [ctfl_pkg::CTX_W-1:0] slot_ctx [TAGS];
  bit                         slot_written [TAGS];
  logic [8:0]                 head_slot;
  logic [ctfl_pkg::TAG_W-1:0] held_tags [$];
  tag_reply_t                 pending_replies [$];
  int                         errors = 0;
  dir_row_t                   dir_tbl [N_DIR];

  context_tag_free_list #(.TAG_COUNT(TAGS)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("tb_context_tag_free_list: FAIL");
    $finish;
  end

  function automatic tag_reply_t apply_tag_op(logic cmd, logic [ctfl_pkg::CTX_W-1:0] ctx,
                                              logic [ctfl_pkg::TAG_W-1:0] idx);
    tag_reply_t r;
    logic [ctfl_pkg::TAG_W-1:0] slot;
    r = '0;
    r.status = ctfl_pkg::STATUS_DONE;
    if (cmd == ctfl_pkg::CMD_ALLOC) begin
      if (head_slot >= TAGS) begin
        r.status = ctfl_pkg::STATUS_EMPTY;
      end else begin
        slot = head_slot[ctfl_pkg::TAG_W-1:0];
        r.tag = slot;
        head_slot = next_free[slot];
        slot_ctx[slot] = ctx;
        slot_written[slot] = 1'b1;
        held_tags.push_back(slot);
      end
    end else begin
      r.tag = idx;
      if (idx < TAGS) begin
        r.ctx = slot_ctx[idx];
        next_free[idx] = head_slot;
        head_slot = {1'b0, idx};
        for (int k = 0; k < held_tags.size(); k++) begin
          if (held_tags[k] == idx) begin
            held_tags.delete(k);
            break;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ctfl_pkg::CTX_W-1:0] want_v,
                                 logic [ctfl_pkg::CTX_W-1:0] got_v);
    errors++;
    $display("%0t mismatch %s: expected %h got %h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : reply_check
    tag_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("beat with nothing pending", '0, {56'b0, tag_index});
      end else begin
        want = pending_replies.pop_front();
        if (tag_index !== want.tag)
          report_mismatch("tag_index", ctfl_pkg::CTX_W'(want.tag),
                          ctfl_pkg::CTX_W'(tag_index));
        if (returned_context !== want.ctx)
          report_mismatch("returned_context", want.ctx, returned_context);
        if (status !== want.status)
          report_mismatch("status", ctfl_pkg::CTX_W'(want.status),
                          ctfl_pkg::CTX_W'(status));
      end
    end
  end

  task automatic send_beat(logic cmd, logic [ctfl_pkg::CTX_W-1:0] ctx,
                           logic [ctfl_pkg::TAG_W-1:0] idx,
                           logic typed, tag_reply_t typed_reply);
    tag_reply_t r;
    start <= 1'b1;
    command <= cmd;
    context_value <= ctx;
    release_tag <= idx;
    do @(posedge clk); while (busy);
    r = apply_tag_op(cmd, ctx, idx);
    pending_replies.push_back(typed ? typed_reply : r);
  endtask

  task automatic idle_sender(int n);
    start <= 1'b0;
    command <= 1'($urandom);
    context_value <= {$urandom, $urandom};
    release_tag <= ctfl_pkg::TAG_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_replies();
    idle_sender(1);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin : stim
    logic                       cmd;
    logic [ctfl_pkg::CTX_W-1:0] ctx;
    logic [ctfl_pkg::TAG_W-1:0] idx;
    logic                       want_free;
    bit                         filling;
    int                         burst_left;
    int                         roll;

    rst <= 1'b1;
    start <= 1'b0;
    command <= ctfl_pkg::CMD_ALLOC;
    context_value <= '0;
    release_tag <= '0;

    for (int i = 0; i < TAGS; i++) begin
      next_free[i] = 9'(i + 1);
      slot_ctx[i] = '0;
      slot_written[i] = 1'b0;
    end
    head_slot = '0;

    dir_tbl = '{
      '{ctfl_pkg::CMD_ALLOC, 64'h0, 8'h00, 1'b1,
        '{8'd0, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_ALLOC, {ctfl_pkg::CTX_W{1'b1}}, 8'hff, 1'b1,
        '{8'd1, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_ALLOC, 64'h8000_0000_0000_0001, 8'h55, 1'b1,
        '{8'd2, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_FREE, {ctfl_pkg::CTX_W{1'b1}}, 8'd1, 1'b1,
        '{8'd1, {ctfl_pkg::CTX_W{1'b1}}, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_ALLOC, 64'h0123_4567_89ab_cdef, 8'haa, 1'b1,
        '{8'd1, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_FREE, 64'h0, 8'd0, 1'b1,
        '{8'd0, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_FREE, 64'h0, 8'd2, 1'b1,
        '{8'd2, 64'h8000_0000_0000_0001, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_ALLOC, 64'h5555_5555_5555_5555, 8'h00, 1'b1,
        '{8'd2, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_ALLOC, 64'haaaa_aaaa_aaaa_aaaa, 8'hff, 1'b1,
        '{8'd0, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_ALLOC, 64'h0, 8'h00, 1'b1,
        '{8'd3, 64'h0, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_FREE, 64'h0, 8'd1, 1'b1,
        '{8'd1, 64'h0123_4567_89ab_cdef, ctfl_pkg::STATUS_DONE}},
      '{ctfl_pkg::CMD_FREE,  64'hffff_0000_ffff_0000, 8'd3, 1'b0, '0},
      '{ctfl_pkg::CMD_FREE,  64'h0,                   8'd0, 1'b0, '0},
      '{ctfl_pkg::CMD_ALLOC, 64'hfedc_ba98_7654_3210, 8'h80, 1'b0, '0},
      '{ctfl_pkg::CMD_ALLOC, 64'h7fff_ffff_ffff_fffe, 8'h7f, 1'b0, '0},
      '{ctfl_pkg::CMD_FREE,  64'h0,                   8'd2, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      send_beat(dir_tbl[i].cmd, dir_tbl[i].ctx, dir_tbl[i].idx, dir_tbl[i].typed,
                dir_tbl[i].reply);
      if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 3));
    end
    wait_replies();

    // random: alternate fill and drain phases so the list runs dry and refills
    filling = 1'b1;
    burst_left = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      want_free = filling ? ($urandom_range(0, 99) < 15) : ($urandom_range(0, 99) < 85);
      idx = ctfl_pkg::TAG_W'($urandom);
      cmd = ctfl_pkg::CMD_ALLOC;
      if (want_free && i >= N_RANDOM - 40 && $urandom_range(0, 3) == 0) begin
        // free of any written slot, possibly a double free, kept to the tail of the run
        do idx = ctfl_pkg::TAG_W'($urandom_range(0, TAGS - 1)); while (!slot_written[idx]);
        cmd = ctfl_pkg::CMD_FREE;
      end else if (want_free && held_tags.size() != 0) begin
        idx = held_tags[$urandom_range(0, held_tags.size() - 1)];
        cmd = ctfl_pkg::CMD_FREE;
      end
      case ($urandom_range(0, 15))
        0: ctx = '0;
        1: ctx = '1;
        default: ctx = {$urandom, $urandom};
      endcase
      send_beat(cmd, ctx, idx, 1'b0, '0);

      if (filling && held_tags.size() >= TAGS && $urandom_range(0, 7) == 0) begin
        filling = 1'b0;
      end else if (!filling && (held_tags.size() == 0 || $urandom_range(0, 199) == 0)) begin
        filling = 1'b1;
      end

      if (i % 450 == 449) begin
        wait_replies();
      end else if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 99) == 0) begin
        burst_left = $urandom_range(30, 120);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll >= 90) idle_sender($urandom_range(8, 40));
        else if (roll >= 55) idle_sender($urandom_range(1, 3));
      end
    end

    wait_replies();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_context_tag_free_list: PASS");
    end else begin
      $display("tb_context_tag_free_list: FAIL");
    end
    $finish;
  end

endmodule
